/* sv/trl_pkg.sv */
// Shared types and constants for the 2D trilateration solver.
// No dependencies; every other file imports this package.
package trl_pkg;

  localparam int COORD_W   = 16;
  localparam int RANGE_W   = 16;
  localparam int FRAC_BITS = 8;
  localparam int POS_W     = 24;
  localparam int COEF_W    = COORD_W + 2;
  localparam int SQ_W      = 2 * COORD_W;
  localparam int CC_W      = SQ_W + 3;
  localparam int DETP_W    = 2 * COEF_W;
  localparam int DET_W     = DETP_W + 1;
  localparam int NUM_W     = CC_W + COEF_W;
  localparam int QB        = POS_W + 2;
  localparam int RW_A      = NUM_W + FRAC_BITS + 1;
  localparam int RW_B      = DET_W + QB;
  localparam int RW        = (RW_A > RW_B) ? RW_A : RW_B;
  localparam int QDEPTH    = 8;
  localparam int QPTR_W    = 3;
  localparam int FRONT_LAT = 4;
  localparam int REG_IDX_W = 3;

  localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

  typedef enum logic [REG_IDX_W-1:0] {
    REG_ANCHOR1_X = 3'd0,
    REG_ANCHOR1_Y = 3'd1,
    REG_ANCHOR2_X = 3'd2,
    REG_ANCHOR2_Y = 3'd3,
    REG_ANCHOR3_X = 3'd4,
    REG_ANCHOR3_Y = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [RANGE_W-1:0] range_one;
    logic [RANGE_W-1:0] range_two;
    logic [RANGE_W-1:0] range_three;
  } meas_t;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic                    degenerate;
    logic                    saturated;
  } fix_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] anchor1_x;
    logic signed [COORD_W-1:0] anchor1_y;
    logic signed [COORD_W-1:0] anchor2_x;
    logic signed [COORD_W-1:0] anchor2_y;
    logic signed [COORD_W-1:0] anchor3_x;
    logic signed [COORD_W-1:0] anchor3_y;
  } anchors_t;

  typedef struct packed {
    logic signed [NUM_W-1:0] numx;
    logic signed [NUM_W-1:0] numy;
    logic signed [DET_W-1:0] det;
    logic                    degen;
  } job_t;

  typedef struct packed {
    logic                    valid;
    logic                    tag;
    logic signed [NUM_W-1:0] num;
    logic signed [DET_W-1:0] den;
  } div_in_t;

  typedef struct packed {
    logic                    valid;
    logic                    tag;
    logic signed [POS_W-1:0] value;
    logic                    sat;
  } div_out_t;

  typedef struct packed {
    logic              valid;
    logic              tag;
    logic              neg;
    logic              ovf;
    logic [RW-1:0]     rem;
    logic [DET_W-1:0]  den_mag;
    logic [QB-1:0]     quo;
  } div_stage_t;

endpackage

/* sv/trl_front.sv */
// Front pipeline: linear system coefficients, determinant and Cramer numerators.
// Depends on trl_pkg.
module trl_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  trl_pkg::meas_t  meas,
  input  trl_pkg::anchors_t anc,
  output logic            job_valid,
  output trl_pkg::job_t   job
);
  import trl_pkg::*;

  logic signed [COORD_W:0]   dx21, dy21, dx32, dy32;
  logic signed [SQ_W-1:0]    sx1, sy1, sx2, sy2, sx3, sy3;

  // stage 1
  logic                      v1;
  logic signed [COEF_W-1:0]  ca1, cb1, cd1, ce1;
  logic [SQ_W-1:0]           rs1, rs2, rs3, xs1, ys1, xs2, ys2, xs3, ys3;
  // stage 2
  logic                      v2;
  logic signed [COEF_W-1:0]  ca2, cb2, cd2, ce2;
  logic signed [CC_W-1:0]    cc2, cf2;
  logic signed [DETP_W-1:0]  dp_a, dp_b;
  // stage 3
  logic                      v3;
  logic signed [DET_W-1:0]   det3;
  logic signed [NUM_W-1:0]   px_a, px_b, py_a, py_b;

  assign dx21 = {anc.anchor2_x[COORD_W-1], anc.anchor2_x} -
                {anc.anchor1_x[COORD_W-1], anc.anchor1_x};
  assign dy21 = {anc.anchor2_y[COORD_W-1], anc.anchor2_y} -
                {anc.anchor1_y[COORD_W-1], anc.anchor1_y};
  assign dx32 = {anc.anchor3_x[COORD_W-1], anc.anchor3_x} -
                {anc.anchor2_x[COORD_W-1], anc.anchor2_x};
  assign dy32 = {anc.anchor3_y[COORD_W-1], anc.anchor3_y} -
                {anc.anchor2_y[COORD_W-1], anc.anchor2_y};

  assign sx1 = anc.anchor1_x * anc.anchor1_x;
  assign sy1 = anc.anchor1_y * anc.anchor1_y;
  assign sx2 = anc.anchor2_x * anc.anchor2_x;
  assign sy2 = anc.anchor2_y * anc.anchor2_y;
  assign sx3 = anc.anchor3_x * anc.anchor3_x;
  assign sy3 = anc.anchor3_y * anc.anchor3_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      job_valid <= 1'b0;
    end else begin
      v1        <= accept;
      v2        <= v1;
      v3        <= v2;
      job_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    // squares and doubled differences
    ca1 <= {dx21, 1'b0};
    cb1 <= {dy21, 1'b0};
    cd1 <= {dx32, 1'b0};
    ce1 <= {dy32, 1'b0};
    rs1 <= meas.range_one * meas.range_one;
    rs2 <= meas.range_two * meas.range_two;
    rs3 <= meas.range_three * meas.range_three;
    xs1 <= sx1;
    ys1 <= sy1;
    xs2 <= sx2;
    ys2 <= sy2;
    xs3 <= sx3;
    ys3 <= sy3;
    // right-hand sides and determinant products
    ca2  <= ca1;
    cb2  <= cb1;
    cd2  <= cd1;
    ce2  <= ce1;
    cc2  <= CC_W'(rs1) - CC_W'(rs2) - CC_W'(xs1) + CC_W'(xs2) - CC_W'(ys1) + CC_W'(ys2);
    cf2  <= CC_W'(rs2) - CC_W'(rs3) - CC_W'(xs2) + CC_W'(xs3) - CC_W'(ys2) + CC_W'(ys3);
    dp_a <= ce1 * ca1;
    dp_b <= cb1 * cd1;
    // numerator products
    det3 <= dp_a - dp_b;
    px_a <= cc2 * ce2;
    px_b <= cf2 * cb2;
    py_a <= cc2 * cd2;
    py_b <= ca2 * cf2;
    // numerators, classify
    job.numx  <= px_a - px_b;
    job.numy  <= py_a - py_b;
    job.det   <= det3;
    job.degen <= (det3 == '0);
  end

endmodule

/* sv/trl_queue.sv */
// Short FIFO between front and back pipelines.
// Depends on trl_pkg.
module trl_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  trl_pkg::job_t        push_job,
  input  logic                 pop,
  output trl_pkg::job_t        head,
  output logic                 nonempty,
  output logic [trl_pkg::QPTR_W:0] count
);
  import trl_pkg::*;

  job_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wptr, rptr;
  logic              do_pop;

  assign do_pop   = pop && (count != '0);
  assign nonempty = (count != '0);
  assign head     = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (do_pop) rptr <= rptr + 1'b1;
      count <= count + (QPTR_W+1)'(push) - (QPTR_W+1)'(do_pop);
    end
  end

endmodule

/* sv/trl_div.sv */
// Pipelined restoring divider: round(num * 2^FRAC_BITS / den), saturated.
// Depends on trl_pkg.
module trl_div (
  input  logic              clk,
  input  logic              rst,
  input  trl_pkg::div_in_t  din,
  output trl_pkg::div_out_t dout
);
  import trl_pkg::*;

  localparam logic [POS_W:0] POS_MIN_MAG_U = {1'b1, {POS_W{1'b0}}} >> 1;

  div_stage_t       st [QB+1];
  logic [NUM_W-1:0] num_mag;
  logic [DET_W-1:0] den_mag;
  logic             s0_valid, s0_tag, s0_neg;
  logic [QB:0]      rnd_wide;
  logic [QB-1:0]    rnd;
  logic             over;
  logic signed [POS_W-1:0] mag_pos;

  // magnitudes and sign
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else begin
      s0_valid <= din.valid;
    end
    s0_tag  <= din.tag;
    s0_neg  <= din.num[NUM_W-1] ^ din.den[DET_W-1];
    num_mag <= din.num[NUM_W-1] ? NUM_W'(-din.num) : NUM_W'(din.num);
    den_mag <= din.den[DET_W-1] ? DET_W'(-din.den) : DET_W'(din.den);
  end

  // scale numerator, flag quotients too large for the quotient register
  always_ff @(posedge clk) begin
    if (rst) begin
      st[0].valid <= 1'b0;
    end else begin
      st[0].valid <= s0_valid;
    end
    st[0].tag     <= s0_tag;
    st[0].neg     <= s0_neg;
    st[0].rem     <= RW'(num_mag) << (FRAC_BITS + 1);
    st[0].ovf     <= ((RW'(num_mag) << (FRAC_BITS + 1)) >= (RW'(den_mag) << QB));
    st[0].den_mag <= den_mag;
    st[0].quo     <= '0;
  end

  // one quotient bit per stage, most significant first
  for (genvar k = 0; k < QB; k++) begin : g_bit
    logic [RW-1:0] trial;
    logic          hit;
    assign trial = RW'(st[k].den_mag) << (QB - 1 - k);
    assign hit   = (st[k].rem >= trial);
    always_ff @(posedge clk) begin
      if (rst) begin
        st[k+1].valid <= 1'b0;
      end else begin
        st[k+1].valid <= st[k].valid;
      end
      st[k+1].tag     <= st[k].tag;
      st[k+1].neg     <= st[k].neg;
      st[k+1].ovf     <= st[k].ovf;
      st[k+1].den_mag <= st[k].den_mag;
      st[k+1].rem     <= hit ? (st[k].rem - trial) : st[k].rem;
      st[k+1].quo     <= {st[k].quo[QB-2:0], hit};
    end
  end

  // quotient carries one extra fraction bit: add half and drop it
  assign rnd_wide = (QB+1)'(st[QB].quo) + 1'b1;
  assign rnd      = rnd_wide[QB:1];
  assign over     = st[QB].ovf ||
                    (st[QB].neg ? (rnd > QB'(POS_MIN_MAG_U)) : (rnd > QB'(POS_MAX)));
  assign mag_pos  = POS_W'(rnd);

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else begin
      dout.valid <= st[QB].valid;
    end
    dout.tag <= st[QB].tag;
    dout.sat <= over;
    if (over) begin
      dout.value <= st[QB].neg ? POS_MIN : POS_MAX;
    end else begin
      dout.value <= st[QB].neg ? -mag_pos : mag_pos;
    end
  end

endmodule

/* sv/trl_back.sv */
// Back pipeline: drain the queue, run both coordinate divisions, form the fix.
// Depends on trl_pkg and trl_div.
module trl_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          avail,
  input  trl_pkg::job_t head,
  output logic          pop,
  output logic          done,
  output trl_pkg::fix_t fix
);
  import trl_pkg::*;

  div_in_t  xin, yin;
  div_out_t xout, yout;

  assign pop = avail;

  always_ff @(posedge clk) begin
    if (rst) begin
      xin.valid <= 1'b0;
      yin.valid <= 1'b0;
    end else begin
      xin.valid <= avail;
      yin.valid <= avail;
    end
    xin.tag <= head.degen;
    yin.tag <= head.degen;
    xin.num <= head.numx;
    yin.num <= head.numy;
    xin.den <= head.det;
    yin.den <= -head.det;
  end

  trl_div u_div_x (.clk(clk), .rst(rst), .din(xin), .dout(xout));
  trl_div u_div_y (.clk(clk), .rst(rst), .din(yin), .dout(yout));

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= xout.valid;
    end
    if (xout.tag) begin
      fix.pos_x      <= '0;
      fix.pos_y      <= '0;
      fix.degenerate <= 1'b1;
      fix.saturated  <= 1'b0;
    end else begin
      fix.pos_x      <= xout.value;
      fix.pos_y      <= yout.value;
      fix.degenerate <= 1'b0;
      fix.saturated  <= xout.sat || yout.sat;
    end
  end

endmodule

/* sv/trilateration_2d_solver.sv */
// 2D trilateration from three configured anchors; one fix per accepted item.
// The accepting edge loads the first of 36 register stages, the last of which drives done
// (4 front, queue, 3 divider setup, 26 quotient-bit, 2 output); one item per cycle while busy is low.
// The quotient-bit pipeline of the two dividers sets the latency.
// Reset (rst, synchronous) clears anchors to zero, the queue and all valid bits.
// Results are strobed on done for one cycle and cannot be held off.
module trilateration_2d_solver (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  trl_pkg::meas_t                    meas,
  output logic                              done,
  output trl_pkg::fix_t                     fix,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [trl_pkg::REG_IDX_W-1:0]     cfg_index,
  input  logic [trl_pkg::COORD_W-1:0]       cfg_data
);
  import trl_pkg::*;

  anchors_t          anc;
  logic              accept;
  logic              job_valid;
  job_t              job;
  job_t              head;
  logic              nonempty;
  logic              pop;
  logic [QPTR_W:0]   q_count;

  // Register writes are always taken; unknown indexes drop silently.
  assign cfg_ready = 1'b1;

  // Hold off new items while the queue could not absorb everything in the front.
  assign busy   = (q_count >= (QPTR_W+1)'(QDEPTH - FRONT_LAT));
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      anc <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ANCHOR1_X: anc.anchor1_x <= cfg_data;
        REG_ANCHOR1_Y: anc.anchor1_y <= cfg_data;
        REG_ANCHOR2_X: anc.anchor2_x <= cfg_data;
        REG_ANCHOR2_Y: anc.anchor2_y <= cfg_data;
        REG_ANCHOR3_X: anc.anchor3_x <= cfg_data;
        REG_ANCHOR3_Y: anc.anchor3_y <= cfg_data;
        default: ;
      endcase
    end
  end

  // Front: coefficients, determinant, numerators; degenerate flag decided here.
  trl_front u_front (
    .clk(clk), .rst(rst), .accept(accept), .meas(meas), .anc(anc),
    .job_valid(job_valid), .job(job)
  );

  // Queue decouples the front from the divider back end.
  trl_queue u_queue (
    .clk(clk), .rst(rst), .push(job_valid), .push_job(job), .pop(pop),
    .head(head), .nonempty(nonempty), .count(q_count)
  );

  // Back: divide both coordinates, round, saturate, register the fix.
  trl_back u_back (
    .clk(clk), .rst(rst), .avail(nonempty), .head(head), .pop(pop),
    .done(done), .fix(fix)
  );

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    done && fix.degenerate |-> fix.pos_x == '0 && fix.pos_y == '0 && !fix.saturated)
    else $error("degenerate fix carries nonzero payload");

  a_sat_bound: assert property (@(posedge clk) disable iff (rst)
    done && fix.saturated |-> fix.pos_x == POS_MAX || fix.pos_x == POS_MIN ||
                              fix.pos_y == POS_MAX || fix.pos_y == POS_MIN)
    else $error("saturated fix has no coordinate at a bound");

  a_reset_quiet: assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe right after reset");

endmodule
